// ===== rtl/core/qrv_pkg.sv =====
// Shared types and constants for the queue with remove-by-value.
package qrv_pkg;

  localparam int DATA_W = 32;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_DRAIN  = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ENTRY = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_APPEND = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_SHIFT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/core/qrv_cell.sv =====
// Queue slot: holds an entry, takes its right neighbor's on shift or remove hit.
module qrv_cell
  import qrv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_cmd_t                cmd,
  input  logic                     left_valid,
  input  logic                     hit_in,
  input  logic                     right_valid,
  input  logic signed [DATA_W-1:0] right_value,
  output logic                     valid,
  output logic signed [DATA_W-1:0] value,
  output logic                     hit_out
);

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;
  logic                     match;

  // The hit chain marks the first matching cell and every cell behind it.
  assign match   = valid_r && (value_r == cmd.value);
  assign hit_out = hit_in || match;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    unique case (cmd.op)
      CELL_APPEND: begin
        if (!valid_r && left_valid) begin
          valid_nxt = 1'b1;
          value_nxt = cmd.value;
        end
      end
      CELL_REMOVE: begin
        if (hit_out) begin
          valid_nxt = right_valid;
          value_nxt = right_value;
        end
      end
      CELL_SHIFT: begin
        valid_nxt = right_valid;
        value_nxt = right_value;
      end
      default: begin
        valid_nxt = valid_r;
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;

endmodule

// ===== rtl/core/queue_with_remove_by_value.sv =====
// Top level of the ordered queue with append, remove-by-value and drain.
//
// Input items arrive on the in_ stream: in_tuser carries the kind (append,
// remove first equal entry, drain) and in_tdata the signed operand.
// Results leave on the out_ stream: out_tdata is the entry, out_tuser the
// status and out_tlast marks the final result of an input item.
// The entries live in a row of DEPTH cells with the head in cell zero.
// Append and remove are accepted one per cycle while in_tready is high,
// take effect at the next edge and give no result but for an append to a
// full queue, whose drop result is presented in the cycle after acceptance.
// A drain of an empty queue gives one result in the cycle after acceptance.
// Other drains hold the input off until the queue is empty: the item sets
// the drain flag, then cell zero is read into the output register and the
// row shifts toward the head once per cycle while results are taken.
// When the receiver stalls, the output register holds its result and the
// drain sequence and input acceptance pause until the result is taken.
// Reset empties the queue and clears any pending result.
module queue_with_remove_by_value
  import qrv_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] operand_value
  input  logic [KIND_W-1:0] in_tuser,   // [1:0] kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] entry_value
  output logic [STAT_W-1:0] out_tuser,  // [1:0] status
  output logic              out_tlast
);

  logic [DEPTH:0]           valid_vec;
  logic signed [DATA_W-1:0] value_w [DEPTH+1];
  logic [DEPTH:0]           hit_w;

  cell_cmd_t                cmd;
  logic                     in_acc;
  logic                     out_free;
  logic                     drain_step;
  kind_t                    kind;

  logic                     drain_r;
  logic                     drain_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic signed [DATA_W-1:0] out_value_nxt;
  status_t                  out_status_r;
  status_t                  out_status_nxt;
  logic                     out_last_r;
  logic                     out_last_nxt;
  logic                     out_load;

  // The slot past the tail reads as an empty cell.
  assign valid_vec[DEPTH] = 1'b0;
  assign value_w[DEPTH]   = '0;
  assign hit_w[0]         = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic left_valid;
    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_valid = valid_vec[i-1];
    end
    qrv_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_valid  (left_valid),
      .hit_in      (hit_w[i]),
      .right_valid (valid_vec[i+1]),
      .right_value (value_w[i+1]),
      .valid       (valid_vec[i]),
      .value       (value_w[i]),
      .hit_out     (hit_w[i+1])
    );
  end

  assign kind       = kind_t'(in_tuser);
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = !drain_r && out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign drain_step = drain_r && out_free;

  always_comb begin
    cmd.value      = signed'(in_tdata);
    cmd.op         = CELL_HOLD;
    drain_nxt      = drain_r;
    out_load       = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (drain_step) begin
      cmd.op         = CELL_SHIFT;
      out_load       = 1'b1;
      out_value_nxt  = value_w[0];
      out_status_nxt = ST_ENTRY;
      out_last_nxt   = !valid_vec[1];
      drain_nxt      = valid_vec[1];
    end else if (in_acc) begin
      unique case (kind)
        KIND_APPEND: begin
          cmd.op = CELL_APPEND;
          if (valid_vec[DEPTH-1]) begin
            out_load       = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = ST_FULL;
            out_last_nxt   = 1'b1;
          end
        end
        KIND_REMOVE: begin
          cmd.op = CELL_REMOVE;
        end
        KIND_DRAIN: begin
          if (valid_vec[0]) begin
            drain_nxt = 1'b1;
          end else begin
            out_load       = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = ST_EMPTY;
            out_last_nxt   = 1'b1;
          end
        end
        default: begin
          cmd.op = CELL_HOLD;
        end
      endcase
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // Occupied cells always form one unbroken run starting at the head.
  a_packed_run: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("queue cells are not packed toward the head");

  // The final drain step leaves the queue empty.
  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_step && !valid_vec[1]) |=> !valid_vec[0])
    else $error("queue not empty after final drain step");

  // An append to a queue with room stores exactly one more entry.
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && kind == KIND_APPEND && !valid_vec[DEPTH-1]) |=>
      ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
    else $error("append did not add one entry");
`endif

endmodule
